// ----- hw/rtl/wts_pkg.sv -----
// Package for the weight-triggered stopwatch: field widths, command,
// event and register codes, and the control structs shared by the modules.
// No dependencies.
package wts_pkg;

  localparam int CMD_W     = 3;
  localparam int WEIGHT_W  = 24;
  localparam int THR_W     = 14;
  localparam int DELAY_W   = 16;
  localparam int LOSS_W    = 17;
  localparam int ELAPSED_W = 32;
  localparam int MS_W      = 7;   // milliseconds within a tenth, 0..99
  localparam int TENTH_W   = 4;
  localparam int SEC_W     = 6;
  localparam int MIN_W     = 6;
  localparam int EVENT_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [THR_W-1:0]   START_THR_RST = THR_W'(100);
  localparam logic [THR_W-1:0]   CLEAR_THR_RST = THR_W'(50);
  localparam logic [DELAY_W-1:0] DELAY_RST     = DELAY_W'(3000);

  localparam logic [MS_W-1:0]    MS_LAST    = MS_W'(99);
  localparam logic [TENTH_W-1:0] TENTH_LAST = TENTH_W'(9);
  localparam logic [SEC_W-1:0]   SEC_LAST   = SEC_W'(59);
  localparam logic [MIN_W-1:0]   MIN_LAST   = MIN_W'(59);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_SAMPLE = 3'd1,
    CMD_START  = 3'd2,
    CMD_STOP   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE       = 2'd0,
    EV_AUTO_START = 2'd1,
    EV_AUTO_CLEAR = 2'd2
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_THR = 2'd0,
    CFG_CLEAR_THR = 2'd1,
    CFG_DELAY     = 2'd2
  } cfg_idx_t;

  // Configuration register values
  typedef struct packed {
    logic [THR_W-1:0]   start_thr;
    logic [THR_W-1:0]   clear_thr;
    logic [DELAY_W-1:0] delay;
  } cfg_t;

  // Control from the flag logic to the time counters
  typedef struct packed {
    logic advance;  // one millisecond passes
    logic clear;    // return all time counters to zero
  } time_ctl_t;

endpackage

// ----- hw/rtl/wts_time.sv -----
// Elapsed millisecond counter with minute, second and tenth digits kept
// alongside it, so no division is needed. Depends on wts_pkg.
module wts_time (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wts_pkg::time_ctl_t                ctl,
  output logic [wts_pkg::ELAPSED_W-1:0]     elapsed_nxt,
  output logic [wts_pkg::MIN_W-1:0]         min_nxt,
  output logic [wts_pkg::SEC_W-1:0]         sec_nxt,
  output logic [wts_pkg::TENTH_W-1:0]       tenth_nxt
);
  import wts_pkg::*;

  logic [ELAPSED_W-1:0] elapsed_r;
  logic [MS_W-1:0]      ms_r, ms_nxt;
  logic [TENTH_W-1:0]   tenth_r;
  logic [SEC_W-1:0]     sec_r;
  logic [MIN_W-1:0]     min_r;

  // Advance the digit chain; a wrap of the 32-bit count zeroes everything
  always_comb begin
    elapsed_nxt = elapsed_r;
    ms_nxt      = ms_r;
    tenth_nxt   = tenth_r;
    sec_nxt     = sec_r;
    min_nxt     = min_r;
    if (ctl.clear || (ctl.advance && (elapsed_r == '1))) begin
      elapsed_nxt = '0;
      ms_nxt      = '0;
      tenth_nxt   = '0;
      sec_nxt     = '0;
      min_nxt     = '0;
    end else if (ctl.advance) begin
      elapsed_nxt = elapsed_r + ELAPSED_W'(1);
      if (ms_r != MS_LAST) begin
        ms_nxt = ms_r + MS_W'(1);
      end else begin
        ms_nxt = '0;
        if (tenth_r != TENTH_LAST) begin
          tenth_nxt = tenth_r + TENTH_W'(1);
        end else begin
          tenth_nxt = '0;
          if (sec_r != SEC_LAST) begin
            sec_nxt = sec_r + SEC_W'(1);
          end else begin
            sec_nxt = '0;
            min_nxt = (min_r == MIN_LAST) ? '0 : min_r + MIN_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      ms_r      <= '0;
      tenth_r   <= '0;
      sec_r     <= '0;
      min_r     <= '0;
    end else begin
      elapsed_r <= elapsed_nxt;
      ms_r      <= ms_nxt;
      tenth_r   <= tenth_nxt;
      sec_r     <= sec_nxt;
      min_r     <= min_nxt;
    end
  end

endmodule

// ----- hw/rtl/wts_ctrl.sv -----
// Run, auto-start and loss flags with the saturating loss counter; decodes
// each command and drives the time counters. Depends on wts_pkg.
module wts_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic [wts_pkg::CMD_W-1:0]     cmd,
  input  logic [wts_pkg::WEIGHT_W-1:0]  weight,
  input  wts_pkg::cfg_t                 cfg,
  output wts_pkg::time_ctl_t            ctl,
  output logic                          running_nxt,
  output logic                          auto_nxt,
  output wts_pkg::event_t               event_nxt
);
  import wts_pkg::*;

  logic              run_r, sbw_r, present_r, armed_r;
  logic [LOSS_W-1:0] loss_r, loss_nxt;
  logic              present_nxt, armed_nxt;

  logic signed [WEIGHT_W-1:0] w;
  logic signed [WEIGHT_W-1:0] start_s, clear_s;
  logic                       above_start, below_clear;
  logic                       auto_start;

  assign w       = $signed(weight);
  assign start_s = $signed({{(WEIGHT_W-THR_W){1'b0}}, cfg.start_thr});
  assign clear_s = $signed({{(WEIGHT_W-THR_W){1'b0}}, cfg.clear_thr});
  assign above_start = (w > start_s);
  assign below_clear = (w < clear_s);
  assign auto_start  = !run_r && !sbw_r && above_start;

  // Decode the command into next flags, loss count and time control
  always_comb begin
    running_nxt = run_r;
    auto_nxt    = sbw_r;
    present_nxt = present_r;
    armed_nxt   = armed_r;
    loss_nxt    = loss_r;
    event_nxt   = EV_NONE;
    ctl         = '0;
    if (fire) begin
      case (cmd_t'(cmd))
        CMD_TICK: begin
          ctl.advance = run_r;
          if (armed_r && (loss_r != '1)) begin
            loss_nxt = loss_r + LOSS_W'(1);
          end
        end
        CMD_SAMPLE: begin
          // Weight above the start threshold starts an idle stopwatch
          if (auto_start) begin
            running_nxt = 1'b1;
            auto_nxt    = 1'b1;
            present_nxt = 1'b1;
            armed_nxt   = 1'b0;
            loss_nxt    = '0;
            event_nxt   = EV_AUTO_START;
          end
          // Track weight loss after an automatic start
          if (auto_nxt) begin
            if (below_clear) begin
              if (present_nxt) begin
                present_nxt = 1'b0;
                armed_nxt   = 1'b1;
                loss_nxt    = '0;
              end else if (armed_nxt && (loss_nxt > {1'b0, cfg.delay})) begin
                running_nxt = 1'b0;
                auto_nxt    = 1'b0;
                present_nxt = 1'b0;
                armed_nxt   = 1'b0;
                loss_nxt    = '0;
                ctl.clear   = 1'b1;
                event_nxt   = EV_AUTO_CLEAR;
              end
            end else begin
              present_nxt = 1'b1;
              armed_nxt   = 1'b0;
              loss_nxt    = '0;
            end
          end
        end
        CMD_START: running_nxt = 1'b1;
        CMD_STOP:  running_nxt = 1'b0;
        CMD_CLEAR: begin
          running_nxt = 1'b0;
          auto_nxt    = 1'b0;
          present_nxt = 1'b0;
          armed_nxt   = 1'b0;
          loss_nxt    = '0;
          ctl.clear   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= 1'b0;
      sbw_r     <= 1'b0;
      present_r <= 1'b0;
      armed_r   <= 1'b0;
      loss_r    <= '0;
    end else begin
      run_r     <= running_nxt;
      sbw_r     <= auto_nxt;
      present_r <= present_nxt;
      armed_r   <= armed_nxt;
      loss_r    <= loss_nxt;
    end
  end

endmodule

// ----- hw/rtl/weight_triggered_stopwatch_top.sv -----
// Weight-triggered stopwatch, top level. A command passes the input register,
// then the flag and counter update into the result register; throughput one
// command per cycle while the result register is not held by out_stall.
// Synchronous active-low reset stops the stopwatch, zeroes the time and flags
// and loads the default thresholds (100, 50) and clear delay (3000 ms).
// Uses wts_pkg, wts_ctrl and wts_time.
module weight_triggered_stopwatch_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wts_pkg::CMD_W-1:0]         in_cmd,
  input  logic [wts_pkg::WEIGHT_W-1:0]      in_weight,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_running,
  output logic                              out_auto_started,
  output logic [wts_pkg::ELAPSED_W-1:0]     out_elapsed_ms,
  output logic [wts_pkg::MIN_W-1:0]         out_minutes_digit,
  output logic [wts_pkg::SEC_W-1:0]         out_seconds_digit,
  output logic [wts_pkg::TENTH_W-1:0]       out_tenths_digit,
  output logic [wts_pkg::EVENT_W-1:0]       out_event_res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wts_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wts_pkg::*;

  logic                 s1_valid_r;
  logic [CMD_W-1:0]     s1_cmd_r;
  logic [WEIGHT_W-1:0]  s1_weight_r;
  logic                 out_valid_r;
  logic                 out_open, fire, in_take;
  cfg_t                 cfg_r;
  time_ctl_t            tctl;
  logic                 running_nxt, auto_nxt;
  event_t               event_nxt;
  logic [ELAPSED_W-1:0] elapsed_nxt;
  logic [MIN_W-1:0]     min_nxt;
  logic [SEC_W-1:0]     sec_nxt;
  logic [TENTH_W-1:0]   tenth_nxt;

  // Handshake: the result register frees when empty or taken
  assign out_open  = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && out_open;
  assign in_stall  = s1_valid_r && !out_open;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r    <= in_cmd;
      s1_weight_r <= in_weight;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_thr <= START_THR_RST;
      cfg_r.clear_thr <= CLEAR_THR_RST;
      cfg_r.delay     <= DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START_THR: cfg_r.start_thr <= cfg_data[THR_W-1:0];
        CFG_CLEAR_THR: cfg_r.clear_thr <= cfg_data[THR_W-1:0];
        CFG_DELAY:     cfg_r.delay     <= cfg_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  wts_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .cmd         (s1_cmd_r),
    .weight      (s1_weight_r),
    .cfg         (cfg_r),
    .ctl         (tctl),
    .running_nxt (running_nxt),
    .auto_nxt    (auto_nxt),
    .event_nxt   (event_nxt)
  );

  wts_time u_time (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (tctl),
    .elapsed_nxt (elapsed_nxt),
    .min_nxt     (min_nxt),
    .sec_nxt     (sec_nxt),
    .tenth_nxt   (tenth_nxt)
  );

  // Result register: load the post-update state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_open) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_running       <= running_nxt;
      out_auto_started  <= auto_nxt;
      out_elapsed_ms    <= elapsed_nxt;
      out_minutes_digit <= min_nxt;
      out_seconds_digit <= sec_nxt;
      out_tenths_digit  <= tenth_nxt;
      out_event_res     <= event_nxt;
    end
  end

endmodule

// ----- hw/rtl/wts_checker.sv -----
// Port-level checks for the weight-triggered stopwatch, bound to the top
// level. Depends on wts_pkg and weight_triggered_stopwatch_top.
module wts_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_running,
  input logic                              out_auto_started,
  input logic [wts_pkg::ELAPSED_W-1:0]     out_elapsed_ms,
  input logic [wts_pkg::MIN_W-1:0]         out_minutes_digit,
  input logic [wts_pkg::SEC_W-1:0]         out_seconds_digit,
  input logic [wts_pkg::TENTH_W-1:0]       out_tenths_digit,
  input logic [wts_pkg::EVENT_W-1:0]       out_event_res
);
  import wts_pkg::*;

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_elapsed_ms)
      && $stable(out_event_res))
    else $error("stalled result changed");

  // Digits stay within their ranges
  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_minutes_digit <= MIN_LAST) && (out_seconds_digit <= SEC_LAST)
      && (out_tenths_digit <= TENTH_LAST))
    else $error("time digit out of range");

  // An automatic clear leaves a stopped, zeroed stopwatch
  a_auto_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_AUTO_CLEAR) |->
      !out_running && !out_auto_started && (out_elapsed_ms == '0))
    else $error("auto clear left state behind");

  // An automatic start leaves a running, weight-started stopwatch
  a_auto_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_AUTO_START) |-> out_running && out_auto_started)
    else $error("auto start flags wrong");

endmodule

bind weight_triggered_stopwatch_top wts_checker u_wts_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_running       (out_running),
  .out_auto_started  (out_auto_started),
  .out_elapsed_ms    (out_elapsed_ms),
  .out_minutes_digit (out_minutes_digit),
  .out_seconds_digit (out_seconds_digit),
  .out_tenths_digit  (out_tenths_digit),
  .out_event_res     (out_event_res)
);
